@@ hw/rtl/shell_command_line_tokenizer_core_assert.svh @@
// assertion macros used by the tokenizer core rtl
`ifndef SHELL_COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH
`define SHELL_COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// next-cycle implication
`define SCLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define SCLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/sclt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sclt_pkg;

    localparam int unsigned WORD_COUNT_MAX_DEF = 255;

    // result queue depth, power of two
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_EOL  = 1'b1;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_WEND = 2'd1,
        KIND_CEND = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_quote     quote_kind;
        logic       escape_pending;
        logic       word_open;
        logic [7:0] words_seen;
        logic       skip_to_eol;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_out;
        logic       background;
        logic [7:0] word_count;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_step;

    localparam t_state STATE_RESET = '{
        quote_kind:     QUOTE_NONE,
        escape_pending: 1'b0,
        word_open:      1'b0,
        words_seen:     8'd0,
        skip_to_eol:    1'b0
    };

    localparam t_result RESULT_NONE = '{
        kind:       KIND_BYTE,
        char_out:   8'd0,
        background: 1'b0,
        word_count: 8'd0,
        last:       1'b0
    };

endpackage

`default_nettype wire

@@ hw/rtl/sclt_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sclt_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;

    modport source (output valid, output mode, output byte_value, input ready);
    modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sclt_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sclt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       background;
    logic [7:0] word_count;
    logic       last;

    modport source (
        output valid, output kind, output char_out, output background,
        output word_count, output last, input ready
    );
    modport sink (
        input valid, input kind, input char_out, input background,
        input word_count, input last, output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/sclt_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sclt_step
    import sclt_pkg::*;
#(
    parameter int unsigned WORD_COUNT_MAX = WORD_COUNT_MAX_DEF
) (
    input  t_state     i_state,
    input  logic       i_mode,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_step      o_step
);

    localparam logic [7:0] CountMax = 8'(WORD_COUNT_MAX);

    t_state     s;
    t_result    res0;
    t_result    res1;
    logic [1:0] num;
    logic [7:0] qc;
    logic [7:0] cnt_closed;
    logic       blank;
    logic       do_end;
    logic       end_bg;

    always_comb begin
        s      = i_state;
        res0   = RESULT_NONE;
        res1   = RESULT_NONE;
        num    = 2'd0;
        do_end = 1'b0;
        end_bg = 1'b0;
        qc     = (i_state.quote_kind == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        blank  = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
        cnt_closed = (i_state.words_seen < CountMax) ? i_state.words_seen + 8'd1
                                                     : i_state.words_seen;

        priority if (i_mode == MODE_EOL) begin
            priority if (i_state.skip_to_eol) begin
                // command already closed at the comment
            end else if (i_state.escape_pending) begin
                res0.kind = KIND_ERR;
                num       = 2'd1;
            end else begin
                do_end = 1'b1;
            end
        end else if (i_state.skip_to_eol) begin
            // comment bytes dropped
        end else if (i_state.escape_pending) begin
            s.escape_pending = 1'b0;
            s.word_open      = 1'b1;
            if ((i_state.quote_kind != QUOTE_NONE) && (i_byte != qc)) begin
                // backslash kept inside quotes
                res0.char_out = CH_BSLASH;
                res1.char_out = i_byte;
                num           = 2'd2;
            end else begin
                res0.char_out = i_byte;
                num           = 2'd1;
            end
        end else if (i_state.quote_kind != QUOTE_NONE) begin
            priority if (i_byte == qc) begin
                s.quote_kind = QUOTE_NONE;
            end else if (i_byte == CH_BSLASH) begin
                s.escape_pending = 1'b1;
            end else begin
                res0.char_out = i_byte;
                num           = 2'd1;
                s.word_open   = 1'b1;
            end
        end else if (blank) begin
            if (i_state.word_open) begin
                res0.kind    = KIND_WEND;
                num          = 2'd1;
                s.words_seen = cnt_closed;
                s.word_open  = 1'b0;
            end
        end else if (i_byte == CH_DQUOTE) begin
            s.quote_kind = QUOTE_DOUBLE;
        end else if (i_byte == CH_SQUOTE) begin
            s.quote_kind = QUOTE_SINGLE;
        end else if (i_byte == CH_HASH) begin
            do_end        = 1'b1;
            s.skip_to_eol = 1'b1;
        end else if (i_byte == CH_AMP) begin
            do_end = 1'b1;
            end_bg = 1'b1;
        end else if (i_byte == CH_SEMI) begin
            do_end = 1'b1;
        end else if (i_byte == CH_BSLASH) begin
            s.escape_pending = 1'b1;
        end else begin
            res0.char_out = i_byte;
            num           = 2'd1;
            s.word_open   = 1'b1;
        end

        // close the open word, then report the command if it has words
        if (do_end) begin
            priority if (i_state.word_open) begin
                res0.kind       = KIND_WEND;
                res1.kind       = KIND_CEND;
                res1.background = end_bg;
                res1.word_count = cnt_closed;
                num             = 2'd2;
            end else if (i_state.words_seen != 8'd0) begin
                res0.kind       = KIND_CEND;
                res0.background = end_bg;
                res0.word_count = i_state.words_seen;
                num             = 2'd1;
            end else begin
                // empty command
            end
            s.words_seen     = 8'd0;
            s.word_open      = 1'b0;
            s.quote_kind     = QUOTE_NONE;
            s.escape_pending = 1'b0;
        end

        if (i_mode == MODE_EOL) begin
            s = STATE_RESET;
        end

        if (num == 2'd2) begin
            res1.last = 1'b1;
        end else if (num == 2'd1) begin
            res0.last = 1'b1;
        end
    end

    assign o_state = s;
    assign o_step  = '{num: num, res0: res0, res1: res1};

endmodule

`default_nettype wire

@@ hw/rtl/shell_command_line_tokenizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shell word splitting tokenizer
//
// i_in carries one item per transfer: mode 0 with a command line byte in
// byte_value, or mode 1 marking end of line. o_out carries results: word
// byte, word end, command end (with background flag and word count) or error;
// last marks the final result caused by one input item.
// each input item gives zero, one or two results. results are written into a
// four entry queue at the input transfer edge and are shown on o_out from the
// queue head, oldest first. one input item is taken every cycle while
// the queue has two free entries; the sustained rate is one byte per cycle,
// bounded by the sink draining one result per cycle when items give two.
// reset (synchronous, active low) empties the queue and returns the parser
// to no open quote, no open word and zero words; i_in.ready is high in the
// first cycle after reset.
// when the sink stalls, results wait in the queue and i_in.ready drops once
// fewer than two entries are free; nothing is lost or repeated.
`include "shell_command_line_tokenizer_core_assert.svh"

module shell_command_line_tokenizer_core
    import sclt_pkg::*;
#(
    parameter int unsigned WORD_COUNT_MAX = WORD_COUNT_MAX_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sclt_in_if.sink     i_in,
    sclt_out_if.source  o_out
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    // parser state
    t_state r_state;
    t_state n_state;
    t_step  step;

    // result queue
    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic [1:0]         push_n;
    logic               in_xfer;
    logic               out_xfer;
    t_result            head;

    sclt_step #(
        .WORD_COUNT_MAX (WORD_COUNT_MAX)
    ) u_step (
        .i_state (r_state),
        .i_mode  (i_in.mode),
        .i_byte  (i_in.byte_value),
        .o_state (n_state),
        .o_step  (step)
    );

    // room for the worst case of two results
    assign i_in.ready = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;
    assign push_n     = in_xfer ? step.num : 2'd0;

    assign n_wr_ptr = r_wr_ptr + PTR_W'(push_n);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(out_xfer);
    assign n_count  = r_count + CNT_W'(push_n) - CNT_W'(out_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= STATE_RESET;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (step.num != 2'd0) begin
                r_mem[r_wr_ptr] <= step.res0;
            end
            if (step.num == 2'd2) begin
                r_mem[PTR_W'(r_wr_ptr + 1'b1)] <= step.res1;
            end
        end
    end

    assign head             = r_mem[r_rd_ptr];
    assign o_out.valid      = (r_count != '0);
    assign o_out.kind       = head.kind;
    assign o_out.char_out   = head.char_out;
    assign o_out.background = head.background;
    assign o_out.word_count = head.word_count;
    assign o_out.last       = head.last;

    // an error or a command end is always the final result of its item
    `SCLT_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, o_out.valid && (o_out.kind == KIND_ERR), o_out.last)
    `SCLT_ASSERT_IMP(a_cend_is_last, i_clk, i_rst_n, o_out.valid && (o_out.kind == KIND_CEND), o_out.last)
    // end of line leaves the parser in its reset state
    `SCLT_ASSERT_NXT(a_eol_clears, i_clk, i_rst_n, in_xfer && (i_in.mode == MODE_EOL), r_state == STATE_RESET)
    // a pop with no push drops the fill level by one
    `SCLT_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, !in_xfer && out_xfer, r_count == CNT_W'($past(r_count) - 1'b1))

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sclt_pkg::*;

    localparam int unsigned WORD_LIMIT  = WORD_COUNT_MAX_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 150;
    localparam int unsigned LONG_WORDS  = 260;
    // row marker: the predictor supplies the expected results
    localparam int PREDICTED = -1;

    localparam t_result WEND_ALONE = '{KIND_WEND, 8'h00, 1'b0, 8'd0, 1'b1};
    localparam t_result ERR_ALONE  = '{KIND_ERR, 8'h00, 1'b0, 8'd0, 1'b1};

    typedef struct {
        logic       mode;
        logic [7:0] ch;
        int         fixed_n;  // typed result count, or PREDICTED
        t_result    fixed_res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    sclt_in_if  in_if ();
    sclt_out_if out_if ();

    shell_command_line_tokenizer_core #(
        .WORD_COUNT_MAX (WORD_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // tokenizer predictor: its own copy of the parser state
    // ------------------------------------------------------------------
    t_quote     quote_st;
    logic       esc_wait;
    logic       word_busy;
    logic [7:0] word_tally;
    logic       comment_skip;
    t_result    step_tokens[$];   // results of the item being predicted
    t_result    token_q[$];       // results still owed by the block

    function automatic void emit_token(t_kind k, logic [7:0] ch, logic bg, logic [7:0] cnt);
        t_result r;
        r.kind       = k;
        r.char_out   = ch;
        r.background = bg;
        r.word_count = cnt;
        r.last       = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void add_word_byte(logic [7:0] ch);
        emit_token(KIND_BYTE, ch, 1'b0, 8'd0);
        word_busy = 1'b1;
    endfunction

    function automatic void finish_word();
        if (word_busy) begin
            emit_token(KIND_WEND, 8'd0, 1'b0, 8'd0);
            if (word_tally < WORD_LIMIT)
                word_tally = word_tally + 8'd1;
            word_busy = 1'b0;
        end
    endfunction

    function automatic void finish_command(logic bg);
        finish_word();
        // a command with no words says nothing
        if (word_tally != 8'd0)
            emit_token(KIND_CEND, 8'd0, bg, word_tally);
        word_tally = 8'd0;
        word_busy  = 1'b0;
        quote_st   = QUOTE_NONE;
        esc_wait   = 1'b0;
    endfunction

    function automatic void clear_parser();
        quote_st     = QUOTE_NONE;
        esc_wait     = 1'b0;
        word_busy    = 1'b0;
        word_tally   = 8'd0;
        comment_skip = 1'b0;
    endfunction

    function automatic void split_item(logic mode, logic [7:0] c);
        logic [7:0] qc;
        step_tokens.delete();
        qc = (quote_st == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        if (mode == MODE_EOL) begin
            if (comment_skip) begin
                // command already closed at the comment mark
            end else if (esc_wait) begin
                // dangling backslash drops the whole command
                emit_token(KIND_ERR, 8'd0, 1'b0, 8'd0);
            end else begin
                finish_command(1'b0);
            end
            clear_parser();
        end else if (comment_skip) begin
            // comment text is swallowed
        end else if (esc_wait) begin
            esc_wait = 1'b0;
            // inside quotes the backslash survives unless it escapes the quote
            if (quote_st != QUOTE_NONE && c != qc)
                add_word_byte(CH_BSLASH);
            add_word_byte(c);
        end else if (quote_st != QUOTE_NONE) begin
            if (c == qc)
                quote_st = QUOTE_NONE;
            else if (c == CH_BSLASH)
                esc_wait = 1'b1;
            else
                add_word_byte(c);
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            finish_word();
        end else begin
            case (c)
                CH_DQUOTE: quote_st = QUOTE_DOUBLE;
                CH_SQUOTE: quote_st = QUOTE_SINGLE;
                CH_HASH: begin
                    finish_command(1'b0);
                    comment_skip = 1'b1;
                end
                CH_AMP:    finish_command(1'b1);
                CH_SEMI:   finish_command(1'b0);
                CH_BSLASH: esc_wait = 1'b1;
                default:   add_word_byte(c);
            endcase
        end
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // shared run state
    // ------------------------------------------------------------------
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned bad_cnt;
    int unsigned cycle_cnt;
    bit          idle_on;    // random gaps on both sides when set
    bit          hold_req;   // asks the sink for one long hold-off
    int          cur_fixed_n;
    t_result     cur_fixed;

    function automatic void report_bad(string what, int unsigned got_v, int unsigned exp_v);
        bad_cnt++;
        if (bad_cnt <= 100)
            $display("mismatch at %0t, result %0d: %s got %0h want %0h",
                     $time, results_seen, what, got_v, exp_v);
    endfunction

    // ------------------------------------------------------------------
    // checker: predicts on every input transfer and compares every
    // output transfer with the oldest owed result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            // predict first so a result in the same cycle would still match
            if (in_if.valid && in_if.ready) begin
                split_item(in_if.mode, in_if.byte_value);
                if (cur_fixed_n == PREDICTED) begin
                    foreach (step_tokens[k])
                        token_q.push_back(step_tokens[k]);
                end else if (cur_fixed_n > 0) begin
                    token_q.push_back(cur_fixed);
                end
            end
            if (out_if.valid && out_if.ready) begin
                got.kind       = t_kind'(out_if.kind);
                got.char_out   = out_if.char_out;
                got.background = out_if.background;
                got.word_count = out_if.word_count;
                got.last       = out_if.last;
                if (token_q.size() == 0) begin
                    report_bad("result with nothing owed, kind", got.kind, 0);
                end else begin
                    want = token_q.pop_front();
                    if (got.kind != want.kind)
                        report_bad("kind", got.kind, want.kind);
                    if (got.char_out != want.char_out)
                        report_bad("char_out", got.char_out, want.char_out);
                    if (got.background != want.background)
                        report_bad("background", got.background, want.background);
                    if (got.word_count != want.word_count)
                        report_bad("word_count", got.word_count, want.word_count);
                    if (got.last != want.last)
                        report_bad("last", got.last, want.last);
                end
                results_seen++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, token_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result sink: random stalls per result, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_proc
        int unsigned stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // long hold-off lets the result queue fill and stall the input
                hold_req = 1'b0;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do begin
                @(posedge i_clk);
            end while (!out_if.valid);
        end
    end

    // ------------------------------------------------------------------
    // line source
    // ------------------------------------------------------------------
    // offers one item from a falling edge and returns at the falling edge
    // after its transfer
    task automatic send_item(logic mode, logic [7:0] ch, int fixed_n, t_result fixed_res);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.mode       = mode;
        in_if.byte_value = ch;
        cur_fixed_n      = fixed_n;
        cur_fixed        = fixed_res;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] ch);
        send_item(MODE_BYTE, ch, PREDICTED, RESULT_NONE);
    endtask

    // byte_value is don't-care on end of line, so it is randomized
    task automatic send_eol();
        send_item(MODE_EOL, 8'($urandom_range(0, 255)), PREDICTED, RESULT_NONE);
    endtask

    // any byte that the parser treats as plain word text
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_HASH || c == CH_AMP ||
                   c == CH_SEMI || c == CH_BSLASH || c == CH_SPACE ||
                   (c >= CH_TAB && c <= CH_CR));
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    // quoted group with random text and occasional escapes
    task automatic send_quoted(logic [7:0] qc);
        logic [7:0] c;
        send_byte(qc);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(CH_BSLASH);
                send_byte(($urandom_range(0, 3) == 0) ? qc : 8'($urandom_range(0, 255)));
            end else begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (c == qc || c == CH_BSLASH);
                send_byte(c);
            end
        end
        send_byte(qc);
    endtask

    // directed lines; typed expectations only where obvious
    t_row directed_rows [0:27] = '{
        '{MODE_BYTE, 8'h00,     1, '{KIND_BYTE, 8'h00, 1'b0, 8'd0, 1'b1}},
        '{MODE_BYTE, 8'hFF,     1, '{KIND_BYTE, 8'hFF, 1'b0, 8'd0, 1'b1}},
        '{MODE_BYTE, CH_SPACE,  1, WEND_ALONE},
        '{MODE_BYTE, CH_SQUOTE, 0, RESULT_NONE},   // empty quote pair
        '{MODE_BYTE, CH_SQUOTE, 0, RESULT_NONE},
        '{MODE_BYTE, CH_DQUOTE, 0, RESULT_NONE},
        '{MODE_BYTE, 8'h61,     PREDICTED, RESULT_NONE},
        '{MODE_BYTE, CH_BSLASH, PREDICTED, RESULT_NONE},
        '{MODE_BYTE, 8'h62,     PREDICTED, RESULT_NONE},  // backslash kept in quotes
        '{MODE_BYTE, CH_BSLASH, PREDICTED, RESULT_NONE},
        '{MODE_BYTE, CH_DQUOTE, PREDICTED, RESULT_NONE},  // escaped closing quote
        '{MODE_BYTE, CH_DQUOTE, PREDICTED, RESULT_NONE},
        '{MODE_BYTE, CH_AMP,    PREDICTED, RESULT_NONE},  // background command end
        '{MODE_BYTE, CH_SEMI,   0, RESULT_NONE},          // empty command
        '{MODE_BYTE, CH_TAB,    0, RESULT_NONE},
        '{MODE_BYTE, CH_BSLASH, PREDICTED, RESULT_NONE},
        '{MODE_BYTE, CH_HASH,   PREDICTED, RESULT_NONE},  // escaped hash is literal
        '{MODE_BYTE, CH_CR,     PREDICTED, RESULT_NONE},
        '{MODE_BYTE, 8'h78,     PREDICTED, RESULT_NONE},
        '{MODE_BYTE, CH_HASH,   PREDICTED, RESULT_NONE},  // comment starts
        '{MODE_BYTE, 8'h7A,     0, RESULT_NONE},
        '{MODE_EOL,  8'hA5,     0, RESULT_NONE},
        '{MODE_BYTE, CH_SQUOTE, PREDICTED, RESULT_NONE},
        '{MODE_BYTE, 8'h63,     PREDICTED, RESULT_NONE},
        '{MODE_EOL,  8'h00,     PREDICTED, RESULT_NONE},  // open quote at end of line
        '{MODE_BYTE, 8'h71,     PREDICTED, RESULT_NONE},
        '{MODE_BYTE, CH_BSLASH, PREDICTED, RESULT_NONE},
        '{MODE_EOL,  8'hFF,     1, ERR_ALONE}             // dangling backslash
    };

    initial begin : source_proc
        int unsigned goal;
        int unsigned pick;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_BYTE;
        in_if.byte_value = 8'd0;
        idle_on          = 1'b1;
        hold_req         = 1'b0;
        cur_fixed_n      = PREDICTED;
        cur_fixed        = RESULT_NONE;
        items_sent       = 0;
        results_seen     = 0;
        bad_cnt          = 0;
        cycle_cnt        = 0;
        clear_parser();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed lines
        foreach (directed_rows[r])
            send_item(directed_rows[r].mode, directed_rows[r].ch,
                      directed_rows[r].fixed_n, directed_rows[r].fixed_res);

        // one long command of one-byte words that drives the word count into saturation
        idle_on = 1'b0;
        for (int w = 0; w < LONG_WORDS; w++) begin
            if (w % 64 == 0)
                idle_on = ~idle_on;
            send_byte(plain_byte());
            send_byte(blank_byte());
        end
        send_byte(($urandom_range(0, 1) == 0) ? CH_AMP : CH_SEMI);
        send_eol();

        // random lines, mostly well formed; sink holds off once early on
        hold_req = 1'b1;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                // noise, optionally ending in a dangling escape or open quote
                repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 2);
                if (pick == 1) begin
                    send_byte(CH_BSLASH);
                end else if (pick == 2) begin
                    send_byte(CH_DQUOTE);
                    send_byte(plain_byte());
                end
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0, 1, 2: repeat ($urandom_range(1, 4)) send_byte(plain_byte());
                        3, 4:    send_byte(blank_byte());
                        5:       send_quoted(CH_SQUOTE);
                        6:       send_quoted(CH_DQUOTE);
                        7: begin
                            send_byte(CH_BSLASH);
                            send_byte(8'($urandom_range(0, 255)));
                        end
                        8:       send_byte(CH_SEMI);
                        default: send_byte(CH_AMP);
                    endcase
                end
                if ($urandom_range(0, 5) == 0) begin
                    send_byte(CH_HASH);
                    repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
                end
            end
            send_eol();
        end

        in_if.valid = 1'b0;
        while (token_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tokenizer run: %0d items in, %0d results out, %0d mismatches",
                 items_sent, results_seen, bad_cnt);
        $display("covered quotes, escapes, comments, separators, count saturation, backpressure");
        if (bad_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
